>>> hdl/tasr_pkg.sv
// Shared constants, types and command/status structs for the stroke rasterizer.
package tasr_pkg;

	localparam int BITMAP_ROWS    = 480;
	localparam int BITMAP_COLUMNS = 640;
	localparam int ROW_W          = $clog2(BITMAP_ROWS);
	localparam int COL_W          = $clog2(BITMAP_COLUMNS);

	// item and register field widths
	localparam int FUNC_W  = 2;
	localparam int MAG_W   = 8;
	localparam int RROW_W  = 9;
	localparam int RCOL_W  = 10;
	localparam int SCALE_W = 6;
	localparam int BAND_W  = 6;
	localparam int PEN_W   = 12;
	localparam int LEN_W   = MAG_W + SCALE_W;
	// signed width for stroke bounds before clipping
	localparam int GEO_W   = 18;

	localparam int S_TDATA_W = 32;
	localparam int M_TDATA_W = 32;

	localparam int PADDR_W   = 4;
	localparam int PDATA_W   = 32;
	localparam int REG_IDX_W = PADDR_W - 2;

	localparam logic [SCALE_W-1:0]      SCALE_RST   = SCALE_W'(1);
	localparam logic [BAND_W-1:0]       BAND_RST    = BAND_W'(0);
	localparam logic signed [PEN_W-1:0] START_X_RST = PEN_W'(320);
	localparam logic signed [PEN_W-1:0] START_Y_RST = PEN_W'(240);

	localparam logic signed [GEO_W-1:0] PEN_MAX_G = GEO_W'(2047);
	localparam logic signed [GEO_W-1:0] PEN_MIN_G = GEO_W'(-2048);
	localparam logic signed [GEO_W-1:0] ROW_MAX_G = GEO_W'(BITMAP_ROWS - 1);
	localparam logic signed [GEO_W-1:0] COL_MAX_G = GEO_W'(BITMAP_COLUMNS - 1);

	typedef enum logic [FUNC_W-1:0] {
		FUNC_STROKE  = 2'd0,
		FUNC_READ    = 2'd1,
		FUNC_RESTART = 2'd2
	} func_t;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_SCALE   = 2'd0,
		REG_BAND    = 2'd1,
		REG_START_X = 2'd2,
		REG_START_Y = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic [SCALE_W-1:0]      scale;
		logic [BAND_W-1:0]       band_width;
		logic signed [PEN_W-1:0] start_x;
		logic signed [PEN_W-1:0] start_y;
	} cfg_t;

	typedef struct packed {
		logic item_load;
		logic len_calc;
		logic rect_calc;
		logic mask_load;
		logic pen_step;
		logic pen_restart;
		logic row_clr_init;
		logic clr_wr;
		logic row_rd;
		logic row_wr;
		logic row_next;
		logic pix_rd;
		logic res_load;
	} cmd_t;

	typedef struct packed {
		func_t func;
		logic  len_zero;
		logic  rect_empty;
		logic  row_last;
		logic  clr_last;
	} sts_t;

endpackage

>>> hdl/thick_axis_stroke_rasterizer_top.sv
// Thick axis stroke rasterizer: stream in, stream out, APB registers.
// One item at a time. Steps from input transfer to result valid: stroke:
//   decode, length, rectangle, mask, then one read and one write of a bitmap
//   row per clipped row drawn; read: decode, pixel read; restart: 480-row clear.
// Next item is taken the cycle after its result is loaded, even if unread.
// Reset: asynchronous; pen and registers load defaults, then a clearing pass
// over all 480 rows zeroes the bitmap with s_tready low.
module thick_axis_stroke_rasterizer_top (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// [0] axis, [1] negative, [9:2] magnitude, [18:10] row, [28:19] column
	input  logic [tasr_pkg::S_TDATA_W-1:0] s_tdata,
	// [1:0] func
	input  logic [tasr_pkg::FUNC_W-1:0]    s_tuser,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// [0] pixel, [12:1] pen_x, [24:13] pen_y
	output logic [tasr_pkg::M_TDATA_W-1:0] m_tdata,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [tasr_pkg::PADDR_W-1:0]   paddr,
	input  logic [tasr_pkg::PDATA_W-1:0]   pwdata,
	output logic [tasr_pkg::PDATA_W-1:0]   prdata,
	output logic                           pready
);
	import tasr_pkg::*;

	cfg_t                    cfg;
	cmd_t                    cmd;
	sts_t                    sts;
	logic                    pixel;
	logic signed [PEN_W-1:0] pen_x, pen_y;

	tasr_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	tasr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	tasr_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.cfg          (cfg),
		.in_func      (s_tuser),
		.in_axis      (s_tdata[0]),
		.in_negative  (s_tdata[1]),
		.in_magnitude (s_tdata[9:2]),
		.in_row       (s_tdata[18:10]),
		.in_column    (s_tdata[28:19]),
		.pixel        (pixel),
		.pen_x        (pen_x),
		.pen_y        (pen_y)
	);

	assign m_tdata = {{(M_TDATA_W - 1 - 2*PEN_W){1'b0}}, pen_y, pen_x, pixel};

endmodule

>>> hdl/tasr_cfg.sv
// APB register file: scale, band width and pen start position.
module tasr_cfg (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [tasr_pkg::PADDR_W-1:0] paddr,
	input  logic [tasr_pkg::PDATA_W-1:0] pwdata,
	output logic [tasr_pkg::PDATA_W-1:0] prdata,
	output logic                         pready,
	output tasr_pkg::cfg_t               cfg
);
	import tasr_pkg::*;

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_en;

	assign idx    = reg_idx_t'(paddr[PADDR_W-1:2]);
	assign wr_en  = psel & penable & pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.scale      <= SCALE_RST;
			cfg_q.band_width <= BAND_RST;
			cfg_q.start_x    <= START_X_RST;
			cfg_q.start_y    <= START_Y_RST;
		end else if (wr_en) begin
			case (idx)
				REG_SCALE:   cfg_q.scale      <= pwdata[SCALE_W-1:0];
				REG_BAND:    cfg_q.band_width <= pwdata[BAND_W-1:0];
				REG_START_X: cfg_q.start_x    <= signed'(pwdata[PEN_W-1:0]);
				REG_START_Y: cfg_q.start_y    <= signed'(pwdata[PEN_W-1:0]);
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_SCALE:   prdata = PDATA_W'(cfg_q.scale);
			REG_BAND:    prdata = PDATA_W'(cfg_q.band_width);
			REG_START_X: prdata = PDATA_W'($unsigned(cfg_q.start_x));
			REG_START_Y: prdata = PDATA_W'($unsigned(cfg_q.start_y));
			default:     prdata = '0;
		endcase
	end

endmodule

>>> hdl/tasr_ctrl.sv
// Sequencer: clearing pass, stroke row loop, pixel read and result handoff.
module tasr_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           s_tvalid,
	output logic           s_tready,
	output logic           m_tvalid,
	input  logic           m_tready,
	input  tasr_pkg::sts_t sts,
	output tasr_pkg::cmd_t cmd
);
	import tasr_pkg::*;

	typedef enum logic [3:0] {
		S_INIT,
		S_IDLE,
		S_DECODE,
		S_CLEAR,
		S_LEN,
		S_RECT,
		S_MASK,
		S_RD,
		S_WR,
		S_PIX,
		S_DONE
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = out_valid_q;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_INIT: begin
				cmd.clr_wr = 1'b1;
				if (sts.clr_last) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (s_tvalid) begin
					cmd.item_load = 1'b1;
					state_d       = S_DECODE;
				end
			end
			S_DECODE: begin
				case (sts.func)
					FUNC_STROKE: state_d = S_LEN;
					FUNC_READ:   state_d = S_PIX;
					FUNC_RESTART: begin
						cmd.pen_restart  = 1'b1;
						cmd.row_clr_init = 1'b1;
						state_d          = S_CLEAR;
					end
					default: state_d = S_DONE;
				endcase
			end
			S_CLEAR: begin
				cmd.clr_wr = 1'b1;
				if (sts.clr_last) state_d = S_DONE;
			end
			S_LEN: begin
				cmd.len_calc = 1'b1;
				state_d      = S_RECT;
			end
			S_RECT: begin
				cmd.rect_calc = 1'b1;
				state_d       = S_MASK;
			end
			S_MASK: begin
				if (sts.len_zero) begin
					state_d = S_DONE;
				end else begin
					cmd.pen_step = 1'b1;
					if (sts.rect_empty) begin
						state_d = S_DONE;
					end else begin
						cmd.mask_load = 1'b1;
						state_d       = S_RD;
					end
				end
			end
			S_RD: begin
				cmd.row_rd = 1'b1;
				state_d    = S_WR;
			end
			S_WR: begin
				cmd.row_wr = 1'b1;
				if (sts.row_last) begin
					state_d = S_DONE;
				end else begin
					cmd.row_next = 1'b1;
					state_d      = S_RD;
				end
			end
			S_PIX: begin
				cmd.pix_rd = 1'b1;
				state_d    = S_DONE;
			end
			S_DONE: begin
				// wait for the output register to empty or drain this cycle
				if (!out_valid_q || m_tready) begin
					cmd.res_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_INIT;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.res_load) out_valid_q <= 1'b1;
			else if (m_tready) out_valid_q <= 1'b0;
		end
	end

endmodule

>>> hdl/tasr_dp.sv
// Datapath: item registers, stroke geometry, pen, bitmap row memory, result register.
module tasr_dp (
	input  logic                                clk,
	input  logic                                arst_n,
	input  tasr_pkg::cmd_t                      cmd,
	output tasr_pkg::sts_t                      sts,
	input  tasr_pkg::cfg_t                      cfg,
	input  logic [tasr_pkg::FUNC_W-1:0]         in_func,
	input  logic                                in_axis,
	input  logic                                in_negative,
	input  logic [tasr_pkg::MAG_W-1:0]          in_magnitude,
	input  logic [tasr_pkg::RROW_W-1:0]         in_row,
	input  logic [tasr_pkg::RCOL_W-1:0]         in_column,
	output logic                                pixel,
	output logic signed [tasr_pkg::PEN_W-1:0]   pen_x,
	output logic signed [tasr_pkg::PEN_W-1:0]   pen_y
);
	import tasr_pkg::*;

	// item fields
	func_t             func_q;
	logic              axis_q;
	logic              neg_q;
	logic [MAG_W-1:0]  mag_q;
	logic [RROW_W-1:0] item_row_q;
	logic [RCOL_W-1:0] item_col_q;
	logic              in_range_q;

	logic [LEN_W-1:0]        len_s1;
	logic signed [PEN_W-1:0] pen_x_q, pen_y_q;

	// geometry
	logic signed [GEO_W-1:0] px, py, lg, bg;
	logic signed [GEO_W-1:0] r_lo, r_hi, c_lo, c_hi;
	logic signed [GEO_W-1:0] r_lo_c, r_hi_c, c_lo_c, c_hi_c;
	logic signed [GEO_W-1:0] pen_raw, pen_sat;
	logic                    empty;

	logic [ROW_W-1:0]        r0_q, r1_q;
	logic [COL_W-1:0]        c0_q, c1_q;
	logic                    empty_q;
	logic signed [PEN_W-1:0] pen_nxt_q;

	logic [BITMAP_COLUMNS-1:0] mask_d, col_mask_q;

	// bitmap, one row per word
	logic [BITMAP_COLUMNS-1:0] bitmap_mem [BITMAP_ROWS];
	logic [BITMAP_COLUMNS-1:0] rd_row_s1;
	logic [BITMAP_COLUMNS-1:0] wr_row;
	logic [ROW_W-1:0]          row_q;
	logic [ROW_W-1:0]          rd_addr;
	logic                      mem_we, mem_re;

	logic                      pixel_q;
	logic signed [PEN_W-1:0]   res_x_q, res_y_q;

	always_ff @(posedge clk) begin
		if (cmd.item_load) begin
			func_q     <= func_t'(in_func);
			axis_q     <= in_axis;
			neg_q      <= in_negative;
			mag_q      <= in_magnitude;
			item_row_q <= in_row;
			item_col_q <= in_column;
			in_range_q <= (32'(in_row) < BITMAP_ROWS) && (32'(in_column) < BITMAP_COLUMNS);
		end
		if (cmd.len_calc) len_s1 <= LEN_W'(mag_q) * LEN_W'(cfg.scale);
	end

	assign px = GEO_W'(pen_x_q);
	assign py = GEO_W'(pen_y_q);
	assign lg = signed'(GEO_W'(len_s1));
	assign bg = signed'(GEO_W'(cfg.band_width));

	always_comb begin
		if (!axis_q) begin
			r_lo = py - bg;
			r_hi = py;
			if (neg_q) begin
				c_lo    = px - lg + GEO_W'(1);
				c_hi    = px;
				pen_raw = px - lg;
			end else begin
				c_lo    = px;
				c_hi    = px + lg - GEO_W'(1);
				pen_raw = px + lg;
			end
		end else begin
			c_lo = px - bg;
			c_hi = px;
			if (neg_q) begin
				// negative Y moves the pen down (larger rows)
				r_lo    = py;
				r_hi    = py + lg - GEO_W'(1);
				pen_raw = py + lg;
			end else begin
				r_lo    = py - lg + GEO_W'(1);
				r_hi    = py;
				pen_raw = py - lg;
			end
		end
		r_lo_c = (r_lo < 0) ? '0 : r_lo;
		c_lo_c = (c_lo < 0) ? '0 : c_lo;
		r_hi_c = (r_hi > ROW_MAX_G) ? ROW_MAX_G : r_hi;
		c_hi_c = (c_hi > COL_MAX_G) ? COL_MAX_G : c_hi;
		empty  = (r_lo_c > r_hi_c) || (c_lo_c > c_hi_c);
		if (pen_raw > PEN_MAX_G)      pen_sat = PEN_MAX_G;
		else if (pen_raw < PEN_MIN_G) pen_sat = PEN_MIN_G;
		else                          pen_sat = pen_raw;
	end

	always_ff @(posedge clk) begin
		if (cmd.rect_calc) begin
			r0_q      <= ROW_W'(r_lo_c);
			r1_q      <= ROW_W'(r_hi_c);
			c0_q      <= COL_W'(c_lo_c);
			c1_q      <= COL_W'(c_hi_c);
			empty_q   <= empty;
			pen_nxt_q <= PEN_W'(pen_sat);
		end
		if (cmd.mask_load) col_mask_q <= mask_d;
	end

	always_comb begin
		for (int c = 0; c < BITMAP_COLUMNS; c++) begin
			mask_d[c] = (COL_W'(c) >= c0_q) && (COL_W'(c) <= c1_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pen_x_q <= START_X_RST;
			pen_y_q <= START_Y_RST;
			row_q   <= '0;
		end else begin
			if (cmd.pen_restart) begin
				pen_x_q <= cfg.start_x;
				pen_y_q <= cfg.start_y;
			end else if (cmd.pen_step) begin
				if (!axis_q) pen_x_q <= pen_nxt_q;
				else         pen_y_q <= pen_nxt_q;
			end
			if (cmd.row_clr_init)             row_q <= '0;
			else if (cmd.mask_load)           row_q <= r0_q;
			else if (cmd.clr_wr || cmd.row_next) row_q <= row_q + ROW_W'(1);
		end
	end

	assign mem_we  = cmd.clr_wr | cmd.row_wr;
	assign wr_row  = cmd.clr_wr ? '0 : (rd_row_s1 | col_mask_q);
	assign mem_re  = cmd.row_rd | (cmd.pix_rd & in_range_q);
	assign rd_addr = cmd.pix_rd ? ROW_W'(item_row_q) : row_q;

	always_ff @(posedge clk) begin
		if (mem_we) bitmap_mem[row_q] <= wr_row;
		if (mem_re) rd_row_s1 <= bitmap_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (cmd.res_load) begin
			pixel_q <= ((func_q == FUNC_READ) && in_range_q) ?
				rd_row_s1[COL_W'(item_col_q)] : 1'b0;
			res_x_q <= pen_x_q;
			res_y_q <= pen_y_q;
		end
	end

	assign pixel = pixel_q;
	assign pen_x = res_x_q;
	assign pen_y = res_y_q;

	assign sts.func       = func_q;
	assign sts.len_zero   = (len_s1 == '0);
	assign sts.rect_empty = empty_q;
	assign sts.row_last   = (row_q == r1_q);
	assign sts.clr_last   = (row_q == ROW_W'(BITMAP_ROWS - 1));

endmodule

>>> hdl/tasr_checker.sv
// Port-level checks for the rasterizer top, bound to every instance.
module tasr_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           s_tvalid,
	input logic                           s_tready,
	input logic                           m_tvalid,
	input logic                           m_tready,
	input logic [tasr_pkg::M_TDATA_W-1:0] m_tdata
);
	import tasr_pkg::*;

	// items taken but not yet handed out
	logic [1:0] pending_q;
	logic       in_xfer, out_xfer;

	assign in_xfer  = s_tvalid & s_tready;
	assign out_xfer = m_tvalid & m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) pending_q <= '0;
		else pending_q <= pending_q + {1'b0, in_xfer} - {1'b0, out_xfer};
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |=> !s_tready)
		else $error("second item taken while one is in work");

	a_no_extra: assert property (@(posedge clk) disable iff (!arst_n)
		out_xfer |-> pending_q != 2'd0)
		else $error("result with no item pending");

	a_pending_bound: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> pending_q <= 2'd1)
		else $error("ready with two items pending");

	a_result_then_ready: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> s_tready)
		else $error("result appeared without returning to ready");

endmodule

bind thick_axis_stroke_rasterizer_top tasr_checker u_tasr_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
